[hdl/tdpc_pkg.sv]
`timescale 1ns / 1ps

package tdpc_pkg;

  // running count width and its saturation value
  localparam int COUNT_W = 31;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // first odd trial divisor and the step between trials
  localparam int DIVISOR_START = 3;
  localparam int DIVISOR_STEP  = 2;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_LAUNCH,
    S_WAIT,
    S_EMIT
  } tdpc_state_t;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } tdpc_div_status_t;

endpackage

[hdl/tdpc_in_if.sv]
`timescale 1ns / 1ps

interface tdpc_in_if #(parameter int VALUE_WIDTH = 32);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] candidate;
  logic                   restart;

  modport source (output valid, output candidate, output restart, input ready);
  modport sink   (input valid, input candidate, input restart, output ready);
endinterface

[hdl/tdpc_out_if.sv]
`timescale 1ns / 1ps

interface tdpc_out_if;
  logic        valid;
  logic        ready;
  logic        prime_flag;
  logic [30:0] running_count;

  modport source (output valid, output prime_flag, output running_count, input ready);
  modport sink   (input valid, input prime_flag, input running_count, output ready);
endinterface

[hdl/tdpc_divider.sv]
`timescale 1ns / 1ps

module tdpc_divider #(
  parameter int VALUE_WIDTH   = 32,
  parameter int DIVISOR_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [VALUE_WIDTH-1:0]              dividend,
  input  logic [DIVISOR_WIDTH-1:0]            divisor,
  output tdpc_pkg::tdpc_div_status_t          status,
  output logic [VALUE_WIDTH-1:0]              quotient,
  output logic [DIVISOR_WIDTH-1:0]            remainder
);
  import tdpc_pkg::*;

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic                     busy;
  logic                     done;
  logic [CNT_W-1:0]         count;
  logic [VALUE_WIDTH-1:0]   work;
  logic [DIVISOR_WIDTH-1:0] rem;

  logic [DIVISOR_WIDTH:0]   shifted;
  logic [DIVISOR_WIDTH:0]   diff;
  logic                     q_bit;

  // one restoring step: shift in next dividend bit, try subtract
  always_comb begin
    shifted = {rem, work[VALUE_WIDTH-1]};
    diff    = shifted - {1'b0, divisor};
    q_bit   = !diff[DIVISOR_WIDTH];
  end

  // control: bit counter, busy and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(VALUE_WIDTH);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: dividend shifts out as quotient shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
    end else if (busy) begin
      work <= {work[VALUE_WIDTH-2:0], q_bit};
      rem  <= q_bit ? diff[DIVISOR_WIDTH-1:0] : shifted[DIVISOR_WIDTH-1:0];
    end
  end

  assign status    = '{busy: busy, done: done};
  assign quotient  = work;
  assign remainder = rem;

endmodule

[hdl/trial_division_prime_counter.sv]
`timescale 1ns / 1ps

// Trial-division primality tester with a saturating running prime count.
// One candidate word is taken at a time; samples.ready stays low until its
// result has been placed in the output register. Negative values, 0, 1, 2
// and even values are decided at once and go from idle straight to the
// emit state. An odd candidate n runs a shared restoring divider, one
// quotient bit per cycle, once for each odd divisor d = 3, 5, ... until d
// divides n or d exceeds n / d; each trial passes through the launch and
// wait states, and a prime needs k = floor((isqrt(n) - 1) / 2) + 1 trials.
// A finished result waits in the output register while the next candidate
// is accepted; restart clears the count before the candidate it comes with
// is counted.
module trial_division_prime_counter #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  tdpc_in_if.sink           samples,
  tdpc_out_if.source        results
);
  import tdpc_pkg::*;

  localparam int DW = (VALUE_WIDTH + 1) / 2;

  tdpc_state_t              state;
  tdpc_state_t              state_next;
  logic [VALUE_WIDTH-1:0]   cand;
  logic                     restart_lat;
  logic [DW-1:0]            trial_divisor;
  logic [COUNT_W-1:0]       prime_total;
  logic                     cand_prime;
  logic                     out_valid;
  logic                     out_flag;
  logic [COUNT_W-1:0]       out_count;

  logic                     accept;
  logic                     div_start;
  logic                     emit_fire;
  tdpc_div_status_t         div_status;
  logic [VALUE_WIDTH-1:0]   quotient;
  logic [DW-1:0]            remainder;

  logic                     in_trivial;
  logic                     in_prime;
  logic                     bound_fail;
  logic                     divides;
  logic [COUNT_W-1:0]       count_base;
  logic [COUNT_W-1:0]       count_next;

  tdpc_divider #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .DIVISOR_WIDTH (DW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (cand),
    .divisor   (trial_divisor),
    .status    (div_status),
    .quotient  (quotient),
    .remainder (remainder)
  );

  // quick classes: negative, below two, two, other even
  always_comb begin
    in_trivial = 1'b1;
    in_prime   = 1'b0;
    priority if (samples.candidate[VALUE_WIDTH-1]) begin
      in_prime = 1'b0;
    end else if (samples.candidate[VALUE_WIDTH-1:1] == '0) begin
      in_prime = 1'b0;
    end else if (samples.candidate == VALUE_WIDTH'(2)) begin
      in_prime = 1'b1;
    end else if (!samples.candidate[0]) begin
      in_prime = 1'b0;
    end else begin
      in_trivial = 1'b0;
    end
  end

  // trial outcome from the divider
  always_comb begin
    bound_fail = VALUE_WIDTH'(trial_divisor) > quotient;
    divides    = remainder == '0;
  end

  // count update applied when the result is emitted
  always_comb begin
    count_base = restart_lat ? '0 : prime_total;
    count_next = (cand_prime && count_base != COUNT_MAX) ? count_base + COUNT_W'(1)
                                                         : count_base;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = in_trivial ? S_EMIT : S_LAUNCH;
      end
      S_LAUNCH: state_next = S_WAIT;
      S_WAIT: begin
        if (div_status.done) state_next = (bound_fail || divides) ? S_EMIT : S_LAUNCH;
      end
      S_EMIT: begin
        if (emit_fire) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    samples.ready = state == S_IDLE;
    accept        = samples.valid && samples.ready;
    div_start     = state == S_LAUNCH;
    emit_fire     = (state == S_EMIT) && (!out_valid || results.ready);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      prime_total   <= '0;
      trial_divisor <= DW'(DIVISOR_START);
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) trial_divisor <= DW'(DIVISOR_START);
      else if (state == S_WAIT && div_status.done && !bound_fail && !divides)
        trial_divisor <= trial_divisor + DW'(DIVISOR_STEP);
      if (emit_fire) begin
        prime_total <= count_next;
        out_valid   <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cand        <= samples.candidate;
      restart_lat <= samples.restart;
      cand_prime  <= in_prime;
    end else if (state == S_WAIT && div_status.done) begin
      cand_prime <= bound_fail;
    end
    if (emit_fire) begin
      out_flag  <= cand_prime;
      out_count <= count_next;
    end
  end

  assign results.valid         = out_valid;
  assign results.prime_flag    = out_flag;
  assign results.running_count = out_count;

endmodule

[hdl/tdpc_checker.sv]
`timescale 1ns / 1ps

module tdpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_prime,
  input logic [30:0] out_count
);
  import tdpc_pkg::*;

  logic               in_acc;
  logic               out_acc;
  logic [COUNT_W-1:0] prev_count;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // count of the last result taken
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_count <= '0;
    end else begin
      if (out_acc) prev_count <= out_count;
    end
  end

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_prime) && $stable(out_count))
    else $error("result dropped or changed while stalled");

  // one word at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("input taken while a word is in work");

  // a non-prime keeps the count or clears it on restart
  a_keep: assert property (@(posedge clk) disable iff (rst)
    out_acc && !out_prime |-> (out_count == prev_count) || (out_count == '0))
    else $error("count changed on a non-prime");

  // a prime steps the count, restarts it at one, or stays at saturation
  a_step: assert property (@(posedge clk) disable iff (rst)
    out_acc && out_prime |-> (out_count == COUNT_W'(1)) ||
                             (out_count == prev_count + COUNT_W'(1)) ||
                             (prev_count == COUNT_MAX && out_count == COUNT_MAX))
    else $error("count step wrong on a prime");

endmodule

bind trial_division_prime_counter tdpc_checker u_tdpc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (samples.valid),
  .in_ready   (samples.ready),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out_prime  (results.prime_flag),
  .out_count  (results.running_count)
);
